// ===== design/pis_pkg.sv =====
// Package for the point-in-sector test core: shared constants, types and
// the CORDIC arctangent table. No dependencies.
`default_nettype none
package pis_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int CFG_DATA_W     = 32;
  localparam int Q15_W          = 16;
  localparam int CW_SQ_W        = 31;
  localparam int HW_RESET       = 8192;

  localparam int CORDIC_STEPS   = 18;
  localparam int CORDIC_CNT_W   = 5;
  localparam logic [31:0] CORDIC_ONE_K = 32'd652032874;

  typedef enum logic [1:0] {
    CFG_CENTER_X   = 2'd0,
    CFG_CENTER_Z   = 2'd1,
    CFG_HEADING    = 2'd2,
    CFG_HALF_WIDTH = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [Q15_W-1:0] sin_h;
    logic signed [Q15_W-1:0] cos_h;
    logic [CW_SQ_W-1:0]      cw_sq;
    logic                    cw_neg;
    logic                    invert;
  } sect_k_t;

  function automatic logic [31:0] atan_turn32(input logic [CORDIC_CNT_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667332;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/pis_cordic.sv =====
// Iterative CORDIC giving Q1.15 sin and cos of an angle in turn units.
// Depends on pis_pkg.
`default_nettype none
module pis_cordic #(
  parameter int ANGLE_BITS = pis_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [ANGLE_BITS-1:0]          angle,
  output logic                                busy,
  output logic signed [pis_pkg::Q15_W-1:0]    sin_q,
  output logic signed [pis_pkg::Q15_W-1:0]    cos_q
);
  import pis_pkg::*;

  localparam int XW = 34;
  localparam int ZW = 33;

  logic                       run_r;
  logic [CORDIC_CNT_W-1:0]    cnt_r;
  logic [1:0]                 q_r;
  logic signed [XW-1:0]       x_r, y_r;
  logic signed [ZW-1:0]       z_r;
  logic signed [Q15_W-1:0]    sin_r, cos_r;
  logic [31:0]                a32;
  logic signed [XW-1:0]       xs, ys, cv, sv;
  logic signed [ZW-1:0]       at;

  function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    logic signed [Q15_W-1:0] o;
    r = (v + XW'(16384)) >>> 15;
    if (r > XW'(32767))
      o = 16'sh7fff;
    else if (r < -XW'(32768))
      o = 16'sh8000;
    else
      o = r[Q15_W-1:0];
    return o;
  endfunction

  assign a32 = 32'(angle) << (32 - ANGLE_BITS);
  assign xs  = x_r >>> cnt_r;
  assign ys  = y_r >>> cnt_r;
  assign at  = $signed({1'b0, atan_turn32(cnt_r)});

  always_comb begin
    case (q_r)
      2'd0: begin cv = x_r;  sv = y_r;  end
      2'd1: begin cv = -y_r; sv = x_r;  end
      2'd2: begin cv = -x_r; sv = -y_r; end
      default: begin cv = y_r; sv = -x_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= '0;
      q_r   <= a32[31:30];
      x_r   <= XW'(CORDIC_ONE_K);
      y_r   <= '0;
      z_r   <= $signed({3'b000, a32[29:0]});
    end else if (run_r) begin
      if (cnt_r == CORDIC_CNT_W'(CORDIC_STEPS)) begin
        run_r <= 1'b0;
        cos_r <= to_q15(cv);
        sin_r <= to_q15(sv);
      end else begin
        cnt_r <= cnt_r + 1'b1;
        if (!z_r[ZW-1]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end
      end
    end
  end

  assign busy  = run_r;
  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule
`default_nettype wire

// ===== design/pis_pipe.sv =====
// Six-stage sector test datapath: offset, products, dot and norm, split
// squares, recombine, compare. Depends on pis_pkg.
`default_nettype none
module pis_pipe #(
  parameter int COORD_BITS = pis_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  output logic                       adv,
  input  wire logic [COORD_BITS-1:0] point_x,
  input  wire logic [COORD_BITS-1:0] point_z,
  input  wire logic [COORD_BITS-1:0] center_x,
  input  wire logic [COORD_BITS-1:0] center_z,
  input  wire pis_pkg::sect_k_t      k,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       hit
);
  import pis_pkg::*;

  localparam int DXW = COORD_BITS + 1;
  localparam int PW  = Q15_W + DXW;
  localparam int UDW = PW;
  localparam int KD  = UDW / 2;
  localparam int HDW = UDW - KD;
  localparam int SQW = 2 * DXW;
  localparam int SW  = SQW + 1;
  localparam int KS  = SW / 2;
  localparam int HSW = SW - KS;
  localparam int W   = 2 * UDW;

  logic [5:0] v_r;

  // stage 1
  logic signed [DXW-1:0] dx1_r, dz1_r;
  // stage 2
  logic signed [PW-1:0]  pcx2_r, pcz2_r;
  logic [SQW-1:0]        sqx2_r, sqz2_r;
  // stage 3
  logic [UDW-1:0]        ud3_r;
  logic                  dneg3_r, zero3_r;
  logic [SW-1:0]         s3_r;
  // stage 4
  logic [2*HDW-1:0]      hh4_r;
  logic [HDW+KD-1:0]     hl4_r;
  logic [2*KD-1:0]       ll4_r;
  logic [HSW+CW_SQ_W-1:0] th4_r;
  logic [KS+CW_SQ_W-1:0]  tl4_r;
  logic                  dneg4_r, zero4_r;
  // stage 5
  logic [W-1:0]          dsq5_r, t5_r;
  logic                  dneg5_r, zero5_r;
  // stage 6
  logic                  res_r;

  logic [DXW-1:0]        adx, adz;
  logic signed [PW:0]    dsum;
  logic                  narrow;

  assign adv  = !v_r[5] || out_ready;
  assign adx  = dx1_r[DXW-1] ? DXW'(-dx1_r) : DXW'(dx1_r);
  assign adz  = dz1_r[DXW-1] ? DXW'(-dz1_r) : DXW'(dz1_r);
  assign dsum = $signed({pcx2_r[PW-1], pcx2_r}) + $signed({pcz2_r[PW-1], pcz2_r});

  always_comb begin
    if (zero5_r)
      narrow = 1'b0;
    else if (!k.cw_neg)
      narrow = !dneg5_r && (dsq5_r >= t5_r);
    else
      narrow = !dneg5_r || (dsq5_r <= t5_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1_r   <= $signed({point_x[COORD_BITS-1], point_x})
               - $signed({center_x[COORD_BITS-1], center_x});
      dz1_r   <= $signed({point_z[COORD_BITS-1], point_z})
               - $signed({center_z[COORD_BITS-1], center_z});

      pcx2_r  <= PW'($signed(k.cos_h)) * PW'(dx1_r);
      pcz2_r  <= PW'($signed(k.sin_h)) * PW'(dz1_r);
      sqx2_r  <= SQW'(adx) * SQW'(adx);
      sqz2_r  <= SQW'(adz) * SQW'(adz);

      ud3_r   <= dsum[PW] ? UDW'(-dsum) : UDW'(dsum);
      dneg3_r <= dsum[PW];
      zero3_r <= (sqx2_r == '0) && (sqz2_r == '0);
      s3_r    <= SW'(sqx2_r) + SW'(sqz2_r);

      hh4_r   <= (2*HDW)'(ud3_r[UDW-1:KD]) * (2*HDW)'(ud3_r[UDW-1:KD]);
      hl4_r   <= (HDW+KD)'(ud3_r[UDW-1:KD]) * (HDW+KD)'(ud3_r[KD-1:0]);
      ll4_r   <= (2*KD)'(ud3_r[KD-1:0]) * (2*KD)'(ud3_r[KD-1:0]);
      th4_r   <= (HSW+CW_SQ_W)'(s3_r[SW-1:KS]) * (HSW+CW_SQ_W)'(k.cw_sq);
      tl4_r   <= (KS+CW_SQ_W)'(s3_r[KS-1:0]) * (KS+CW_SQ_W)'(k.cw_sq);
      dneg4_r <= dneg3_r;
      zero4_r <= zero3_r;

      dsq5_r  <= (W'(hh4_r) << (2 * KD)) + (W'(hl4_r) << (KD + 1)) + W'(ll4_r);
      t5_r    <= (W'(th4_r) << KS) + W'(tl4_r);
      dneg5_r <= dneg4_r;
      zero5_r <= zero4_r;

      res_r   <= narrow ^ k.invert;
    end
  end

  assign out_valid = v_r[5];
  assign hit       = res_r;

endmodule
`default_nettype wire

// ===== design/point_in_sector_test_core.sv =====
// Point-in-sector test core: top level with config registers, sin/cos setup
// and the test pipeline. Depends on pis_pkg, pis_cordic and pis_pipe.
//
// Each word (point_x, point_z) is tested against a fan sector with apex
// (center_x, center_z), axis heading and half angle half_width; angles are
// in 2^ANGLE_BITS units per turn. One point per cycle is accepted while
// the output does not stall and the constants are settled; its result
// leaves through a six-stage multiplier pipeline. After reset and after
// every config write, two 18-step CORDIC units recompute the sector sines
// and cosines; in_ready stays low while they run. Config writes are taken
// at any time but must only be issued while no point is in flight.
`default_nettype none
module point_in_sector_test_core #(
  parameter int COORD_BITS = pis_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = pis_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [COORD_BITS-1:0]   in_point_x,
  input  wire logic signed [COORD_BITS-1:0]   in_point_z,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_inside_res,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire pis_pkg::cfg_idx_t              cfg_index,
  input  wire logic [pis_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pis_pkg::*;

  localparam logic [ANGLE_BITS-1:0] HALF_TURN    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic [COORD_BITS-1:0] cx_r, cz_r;
  logic [ANGLE_BITS-1:0] hd_r;
  logic [ANGLE_BITS-2:0] hw_r;
  logic                  start_r, settle_r;
  logic [CW_SQ_W-1:0]    cw_sq_r;

  logic                  cfg_acc, in_acc, pipe_adv;
  logic                  busy_h, busy_w, inv;
  logic [ANGLE_BITS-1:0] hw_ext, h_eff, w_eff;
  logic signed [Q15_W-1:0] sin_h, cos_h, sin_w, cos_w;
  logic signed [2*Q15_W-1:0] cw_prod;
  sect_k_t               k;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cz_r <= '0;
      hd_r <= '0;
      hw_r <= (ANGLE_BITS-1)'(HW_RESET);
    end else if (cfg_acc) begin
      case (cfg_index)
        CFG_CENTER_X:   cx_r <= cfg_wdata[COORD_BITS-1:0];
        CFG_CENTER_Z:   cz_r <= cfg_wdata[COORD_BITS-1:0];
        CFG_HEADING:    hd_r <= cfg_wdata[ANGLE_BITS-1:0];
        CFG_HALF_WIDTH: hw_r <= cfg_wdata[ANGLE_BITS-2:0];
        default: ;
      endcase
    end
  end

  // wide sectors are the complement of a narrow one facing the other way
  assign hw_ext = {1'b0, hw_r};
  assign inv    = hw_ext > QUARTER_TURN;
  assign h_eff  = inv ? hd_r + HALF_TURN : hd_r;
  assign w_eff  = inv ? HALF_TURN - hw_ext : hw_ext;

  pis_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_h (
    .clk, .rst_n, .start(start_r), .angle(h_eff),
    .busy(busy_h), .sin_q(sin_h), .cos_q(cos_h)
  );

  pis_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_w (
    .clk, .rst_n, .start(start_r), .angle(w_eff),
    .busy(busy_w), .sin_q(sin_w), .cos_q(cos_w)
  );

  assign cw_prod = (2*Q15_W)'(cos_w) * (2*Q15_W)'(cos_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= 1'b1;
      settle_r <= 1'b0;
    end else begin
      start_r  <= cfg_acc;
      settle_r <= !start_r && !busy_h && !busy_w;
    end
  end

  always_ff @(posedge clk) begin
    cw_sq_r <= cw_prod[CW_SQ_W-1:0];
  end

  always_comb begin
    k.sin_h  = sin_h;
    k.cos_h  = cos_h;
    k.cw_sq  = cw_sq_r;
    k.cw_neg = cos_w[Q15_W-1];
    k.invert = inv;
  end

  assign in_ready = pipe_adv && settle_r && !start_r;
  assign in_acc   = in_valid && in_ready;

  pis_pipe #(.COORD_BITS(COORD_BITS)) u_pipe (
    .clk, .rst_n,
    .accept(in_acc), .adv(pipe_adv),
    .point_x(in_point_x), .point_z(in_point_z),
    .center_x(cx_r), .center_z(cz_r), .k(k),
    .out_valid(out_valid), .out_ready(out_ready), .hit(out_inside_res)
  );

  a_accept_settled: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !busy_h && !busy_w && !start_r)
    else $error("point accepted while sector constants are being computed");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> !in_ready)
    else $error("input not blocked after config write");

  a_cw_sq_range: assert property (@(posedge clk) disable iff (!rst_n)
    settle_r |-> cw_sq_r <= 31'h40000000)
    else $error("squared cosine out of range");

  a_sin_w_sign: assert property (@(posedge clk) disable iff (!rst_n)
    settle_r |-> !sin_w[Q15_W-1])
    else $error("sine of reduced half angle negative");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inside_res))
    else $error("result changed while stalled");

endmodule
`default_nettype wire
